FILE: hw/rtl/mepm_pkg.sv
package mepm_pkg;

    localparam int unsigned POOL_SECTIONS = 8;
    localparam int unsigned SECTION_BYTES = 16;

    typedef enum logic [1:0] {
        OP_ABSORB = 2'd0,
        OP_SET_SEC = 2'd1,
        OP_READ = 2'd2,
        OP_WRITE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_XOR,
        ST_RESP
    } t_state;

    // Handshake between the sequencer and the MD5 round engine.
    typedef struct packed {
        logic init;
        logic load;
        logic step;
        logic fold;
    } t_md5_ctl;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
        };
        return k[i];
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage

FILE: hw/rtl/mepm_if.sv
interface mepm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [6:0] pool_index;
    logic [2:0] section;
    modport source (output valid, opcode, data_byte, last_byte, pool_index, section,
                    input ready);
    modport sink (input valid, opcode, data_byte, last_byte, pool_index, section,
                  output ready);
endinterface

interface mepm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       chunk_mixed;
    modport source (output valid, read_byte, chunk_mixed, input ready);
    modport sink (input valid, read_byte, chunk_mixed, output ready);
endinterface

FILE: hw/rtl/mepm_md5_round.sv
// One MD5 step per cycle while i_ctl.step is high, on a shared adder/rotate datapath.
module mepm_md5_round (
    input  logic                 i_clk,
    input  mepm_pkg::t_md5_ctl   i_ctl,
    input  logic [5:0]           i_rnd,
    input  logic [3:0]           i_widx,
    input  logic [31:0]          i_word,
    output logic [127:0]         o_digest
);
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_h0, r_h1, r_h2, r_h3;
    logic [31:0] f, sum, rot;
    logic [4:0]  sh;

    always_comb begin
        unique case (i_rnd[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + mepm_pkg::md5_k(i_rnd) + r_w[mepm_pkg::md5_g(i_rnd)];
        sh  = mepm_pkg::md5_s(i_rnd);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_w[i_widx] <= i_word;
        end
        if (i_ctl.init) begin
            r_h0 <= 32'h67452301; r_h1 <= 32'hefcdab89;
            r_h2 <= 32'h98badcfe; r_h3 <= 32'h10325476;
            r_a <= 32'h67452301; r_b <= 32'hefcdab89;
            r_c <= 32'h98badcfe; r_d <= 32'h10325476;
        end else if (i_ctl.step) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end else if (i_ctl.fold) begin
            r_h0 <= r_h0 + r_a; r_h1 <= r_h1 + r_b;
            r_h2 <= r_h2 + r_c; r_h3 <= r_h3 + r_d;
            r_a <= r_h0 + r_a; r_b <= r_h1 + r_b;
            r_c <= r_h2 + r_c; r_d <= r_h3 + r_d;
        end
    end

    assign o_digest = {r_h3, r_h2, r_h1, r_h0};
endmodule

FILE: hw/rtl/md5_entropy_pool_mixer_core.sv
// Ops 1..3 and an absorb that leaves the chunk open go through ST_RESP to a registered
// response valid; a new request is only taken once the response has been taken.
// Chunk mix on the single MD5 step unit: per 64-byte block every byte is fetched by a
// registered pool read, then 64 rounds and 1 fold, up to (16*P + 88)/64 blocks, then
// the digest is XORed into the current section before the response. One at a time.
// Reset (synchronous, i_rst_n low) starts a clear of the whole pool, run after release, ready low.
module md5_entropy_pool_mixer_core #(
    parameter int unsigned POOL_SECTIONS = mepm_pkg::POOL_SECTIONS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mepm_in_if.sink      i_req,
    mepm_out_if.source   o_rsp
);
    localparam int unsigned PB    = POOL_SECTIONS * 16;
    localparam int unsigned PW    = $clog2(PB);
    localparam int unsigned SW    = $clog2(POOL_SECTIONS);
    localparam int unsigned MAXL  = 16 + PB;
    localparam int unsigned NBLK  = (MAXL + 8) / 64 + 1;
    localparam int unsigned MW    = $clog2(NBLK * 64 + 1);

    mepm_pkg::t_state r_st, n_st;
    mepm_pkg::t_md5_ctl ctl;

    logic [7:0]  r_pool [PB];
    logic [7:0]  r_chunk [16];
    logic [4:0]  r_fill;
    logic [SW-1:0] r_sec;
    logic        r_clr;
    logic [PW:0] r_ccnt;

    logic [1:0]  r_op;
    logic [7:0]  r_dat;
    logic        r_last;
    logic [6:0]  r_idx;
    logic [7:0]  r_rd, r_pool_q;
    logic        r_mixed;
    logic        r_rsp_v;

    logic [MW-1:0] r_len;   // message bytes
    logic [MW-1:0] r_pos;   // byte position being fetched
    logic [1:0]  r_bsel;
    logic [31:0] r_word;
    logic [3:0]  r_wcnt;
    logic [5:0]  r_rnd;
    logic [4:0]  r_xcnt;
    logic        r_wr_ld;
    logic [127:0] digest;

    // Byte of the padded message at r_pos (chunk, pool, pad, length).
    logic [MW-1:0] pool_off, pad_end;
    logic [MW+2:0] bits;
    logic [7:0]    mbyte;
    logic [PW-1:0] raddr;
    logic          in_pool;

    always_comb begin
        pool_off = r_pos - MW'(r_fill);
        pad_end  = MW'(((r_len + 8) >> 6) + 1) << 6;
        bits     = {r_len, 3'b000};
        in_pool  = (r_pos >= MW'(r_fill)) && (r_pos < r_len);
        raddr    = PW'(pool_off);
        if (r_st == mepm_pkg::ST_XOR) raddr = PW'({r_sec, r_xcnt[3:0]});
        if (r_st == mepm_pkg::ST_IDLE) raddr = PW'(i_req.pool_index);
    end

    always_comb begin
        if (r_pos < MW'(r_fill)) mbyte = r_chunk[r_pos[3:0]];
        else if (in_pool) mbyte = r_pool_q;
        else if (r_pos == r_len) mbyte = 8'h80;
        else if (r_pos >= pad_end - MW'(8))
            mbyte = 8'((bits >> {r_pos[2:0], 3'b000}) & 8'hff);
        else mbyte = 8'h00;
    end

    logic accept, pend_mix, fetch;
    assign accept = i_req.valid & i_req.ready;
    assign i_req.ready = (r_st == mepm_pkg::ST_IDLE) && !r_clr && !r_rsp_v;
    assign pend_mix = (r_op == mepm_pkg::OP_ABSORB) &&
                      (r_last || r_fill == 5'd16);
    assign fetch = (r_st == mepm_pkg::ST_LOAD);

    // Section request value reduced below POOL_SECTIONS by compare and subtract.
    logic [3:0] sec_mod;
    always_comb begin
        sec_mod = {1'b0, i_req.section};
        for (int j = 0; j < 3; j++) begin
            if (32'(sec_mod) >= POOL_SECTIONS) sec_mod = sec_mod - 4'(POOL_SECTIONS);
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            mepm_pkg::ST_IDLE: if (accept) n_st = mepm_pkg::ST_RESP;
            mepm_pkg::ST_RESP: begin
                if (pend_mix) n_st = mepm_pkg::ST_LOAD;
                else n_st = mepm_pkg::ST_IDLE;
            end
            mepm_pkg::ST_LOAD:
                if (r_wr_ld && r_wcnt == 4'd15 && r_bsel == 2'd3) n_st = mepm_pkg::ST_ROUND;
            mepm_pkg::ST_ROUND: if (r_rnd == 6'd63) n_st = mepm_pkg::ST_ADD;
            mepm_pkg::ST_ADD: begin
                if (r_pos >= pad_end) n_st = mepm_pkg::ST_XOR;
                else n_st = mepm_pkg::ST_LOAD;
            end
            mepm_pkg::ST_XOR: if (r_xcnt == 5'd16) n_st = mepm_pkg::ST_IDLE;
            default: n_st = mepm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        ctl.init = (r_st == mepm_pkg::ST_RESP) && pend_mix;
        ctl.load = fetch && r_wr_ld && r_bsel == 2'd3;
        ctl.step = (r_st == mepm_pkg::ST_ROUND);
        ctl.fold = (r_st == mepm_pkg::ST_ADD);
    end

    mepm_md5_round u_round (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_rnd    (r_rnd),
        .i_widx   (r_wcnt),
        .i_word   ({mbyte, r_word[31:8]}),
        .o_digest (digest)
    );

    // Pool RAM: one write port, registered read.
    logic          pw_en;
    logic [PW-1:0] pw_addr;
    logic [7:0]    pw_dat;
    always_comb begin
        pw_en = 1'b0; pw_addr = PW'(r_ccnt); pw_dat = 8'h00;
        if (r_clr) begin
            pw_en = 1'b1;
        end else if (r_st == mepm_pkg::ST_XOR && r_xcnt != 5'd0) begin
            pw_en   = 1'b1;
            pw_addr = PW'({r_sec, 4'(r_xcnt - 5'd1)});
            pw_dat  = r_pool_q ^ 8'(digest >> {4'(r_xcnt - 5'd1), 3'b000});
        end else if (r_st == mepm_pkg::ST_RESP && r_op == mepm_pkg::OP_WRITE &&
                     32'(r_idx) < PB) begin
            pw_en = 1'b1; pw_addr = PW'(r_idx); pw_dat = r_dat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pw_en) r_pool[pw_addr] <= pw_dat;
        r_pool_q <= r_pool[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= mepm_pkg::ST_IDLE;
            r_clr <= 1'b1; r_ccnt <= '0;
            r_fill <= '0; r_sec <= '0; r_rsp_v <= 1'b0;
            r_op <= mepm_pkg::OP_SET_SEC; r_last <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_clr) begin
                r_ccnt <= r_ccnt + 1'b1;
                if (r_ccnt == (PW+1)'(PB - 1)) r_clr <= 1'b0;
            end
            if (o_rsp.valid && o_rsp.ready) r_rsp_v <= 1'b0;
            if (accept) begin
                r_op <= i_req.opcode; r_dat <= i_req.data_byte;
                r_last <= i_req.last_byte; r_idx <= i_req.pool_index;
                if (i_req.opcode == mepm_pkg::OP_ABSORB) begin
                    if (r_fill < 5'd16) r_chunk[r_fill[3:0]] <= i_req.data_byte;
                    r_fill <= r_fill + 1'b1;
                end
                if (i_req.opcode == mepm_pkg::OP_SET_SEC)
                    r_sec <= SW'(sec_mod);
            end
            if (r_st == mepm_pkg::ST_RESP) begin
                r_rd <= (r_op == mepm_pkg::OP_READ && 32'(r_idx) < PB) ? r_pool_q : 8'h00;
                r_mixed <= pend_mix;
                r_len <= MW'(r_fill) + MW'(PB);
                r_pos <= '0; r_bsel <= '0; r_wcnt <= '0; r_wr_ld <= 1'b0;
                r_rnd <= '0; r_xcnt <= '0;
                if (!pend_mix) r_rsp_v <= 1'b1;
            end
            // Byte fetch: address presented while r_wr_ld is low, RAM data valid next, with r_wr_ld high.
            if (fetch) begin
                r_wr_ld <= !r_wr_ld;
                if (r_wr_ld) begin
                    r_word <= {mbyte, r_word[31:8]};
                    r_bsel <= r_bsel + 1'b1;
                    if (r_bsel == 2'd3) r_wcnt <= r_wcnt + 1'b1;
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (r_st == mepm_pkg::ST_ROUND) r_rnd <= r_rnd + 1'b1;
            if (r_st == mepm_pkg::ST_XOR) begin
                r_xcnt <= r_xcnt + 1'b1;
                if (r_xcnt == 5'd16) begin
                    r_sec <= (32'(r_sec) == POOL_SECTIONS - 1) ? '0 : r_sec + 1'b1;
                    r_fill <= '0;
                    r_rsp_v <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.read_byte = r_rd;
    assign o_rsp.chunk_mixed = r_mixed;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> r_st == mepm_pkg::ST_IDLE) else $error("ready while busy");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'd16) else $error("chunk fill overflow");
    a_mix_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.chunk_mixed) |-> r_fill == 5'd0)
        else $error("fill not cleared after mix");
endmodule
